// ===== hdl/majority_clocked_lfsr_keystream_core_macros.svh =====
// assertion macros for the keystream core checker
`ifndef MAJORITY_CLOCKED_LFSR_KEYSTREAM_CORE_MACROS_SVH
`define MAJORITY_CLOCKED_LFSR_KEYSTREAM_CORE_MACROS_SVH

// same-cycle implication, off while reset is high
`define MCLKS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keystream core check failed");

// next-cycle implication, off while reset is high
`define MCLKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keystream core check failed");

// next-cycle implication, also checked across reset
`define MCLKS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("keystream core check failed");

`endif

// ===== hdl/mclks_pkg.sv =====
package mclks_pkg;

  // keystream length and clocking schedule
  localparam int KEYSTREAM_BYTES = 126;
  localparam int BYTES_PER_WORD  = 8;
  localparam int FRAME_CLOCKS    = 64;
  localparam int SILENT_CLOCKS   = 384;
  localparam int TOTAL_BITS      = KEYSTREAM_BYTES * 8;
  localparam int WORDS           = (KEYSTREAM_BYTES + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
  localparam int LAST_BYTES      = KEYSTREAM_BYTES - (WORDS - 1) * BYTES_PER_WORD;
  localparam int LAST_SHIFT      = 64 - LAST_BYTES * 8;
  localparam int CNT_W           = $clog2((TOTAL_BITS > SILENT_CLOCKS) ?
                                          TOTAL_BITS : SILENT_CLOCKS);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // feedback tap masks of the three registers
  localparam logic [63:0] MASK_ONE   = 64'hF206_DCBE_1006_1E29;
  localparam logic [63:0] MASK_TWO   = 64'hD998_073E_C97A_B729;
  localparam logic [63:0] MASK_THREE = 64'hA8CF_BE5D_BEC7_C7F6;

  typedef struct packed {
    logic [63:0] key_word_one;
    logic [63:0] key_word_two;
    logic [63:0] key_word_three;
    logic [63:0] frame_value;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_SILENT,
    ST_STREAM
  } back_state_t;

  // one conditional step of a register under majority clocking
  function automatic logic [63:0] lfsr_step(input logic [63:0] lfsr,
                                            input logic [63:0] mask,
                                            input logic        maj);
    logic [63:0] res;
    res = lfsr;
    if (lfsr[31] == maj) begin
      res = {lfsr[62:0], ^(lfsr & mask)};
    end
    return res;
  endfunction

endpackage

// ===== hdl/mclks_req_if.sv =====
interface mclks_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_word_one;
  logic [63:0] key_word_two;
  logic [63:0] key_word_three;
  logic [63:0] frame_value;

  modport source (output valid, output key_word_one, output key_word_two,
                  output key_word_three, output frame_value, input ready);
  modport sink   (input valid, input key_word_one, input key_word_two,
                  input key_word_three, input frame_value, output ready);
endinterface

// ===== hdl/mclks_word_if.sv =====
interface mclks_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] stream_word;
  logic [3:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, output stream_word, output valid_bytes,
                  output last_word, input ready);
  modport sink   (input valid, input stream_word, input valid_bytes,
                  input last_word, output ready);
endinterface

// ===== hdl/mclks_front.sv =====
module mclks_front (
  input  logic               clk,
  input  logic               rst,
  mclks_req_if.sink          req,
  output logic               push,
  output mclks_pkg::req_t    push_item,
  input  logic               queue_full
);

  logic            hold_valid;
  mclks_pkg::req_t hold_item;

  // one holding stage in front of the queue
  assign push      = hold_valid && !queue_full;
  assign push_item = hold_item;
  assign req.ready = !hold_valid || !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req.ready) begin
      hold_valid <= req.valid;
    end
  end

  // capture the request word
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hold_item.key_word_one   <= req.key_word_one;
      hold_item.key_word_two   <= req.key_word_two;
      hold_item.key_word_three <= req.key_word_three;
      hold_item.frame_value    <= req.frame_value;
    end
  end

endmodule

// ===== hdl/mclks_queue.sv =====
module mclks_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mclks_pkg::req_t push_item,
  output logic            full,
  output logic            pop_valid,
  output mclks_pkg::req_t pop_item,
  input  logic            pop
);

  mclks_pkg::req_t                     entries [mclks_pkg::QUEUE_DEPTH];
  logic [mclks_pkg::QPTR_W-1:0]        head;
  logic [mclks_pkg::QPTR_W-1:0]        tail;
  logic [mclks_pkg::QCNT_W-1:0]        fill;
  logic                                do_push;
  logic                                do_pop;

  assign full      = (fill == mclks_pkg::QCNT_W'(mclks_pkg::QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_item  = entries[head];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + 1'b1;
      end
      if (do_pop) begin
        head <= head + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= push_item;
    end
  end

endmodule

// ===== hdl/mclks_back.sv =====
module mclks_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  mclks_pkg::req_t item,
  output logic            item_pop,
  mclks_word_if.source    word
);

  mclks_pkg::back_state_t          state;
  mclks_pkg::back_state_t          state_next;
  logic [mclks_pkg::CNT_W-1:0]     count;
  logic [mclks_pkg::CNT_W-1:0]     count_next;
  logic [63:0]                     lfsr_one;
  logic [63:0]                     lfsr_two;
  logic [63:0]                     lfsr_three;
  logic [63:0]                     lfsr_one_next;
  logic [63:0]                     lfsr_two_next;
  logic [63:0]                     lfsr_three_next;
  logic [63:0]                     frame;
  logic [63:0]                     frame_next;
  logic [63:0]                     acc;
  logic [63:0]                     acc_next;
  logic                            out_valid;
  logic                            out_valid_next;
  logic [63:0]                     out_word;
  logic [3:0]                      out_bytes;
  logic                            out_last;
  logic                            emit;
  logic                            maj;
  logic [63:0]                     step_one;
  logic [63:0]                     step_two;
  logic [63:0]                     step_three;
  logic                            stream_bit;
  logic [63:0]                     acc_shift;
  logic                            last_bit;
  logic                            word_end;
  logic                            stall;

  // majority of bit 31 of each register, the clock bits, and the stepped registers
  always_comb begin
    maj = (lfsr_one[31] & lfsr_two[31]) | (lfsr_one[31] & lfsr_three[31]) |
          (lfsr_two[31] & lfsr_three[31]);
    step_one   = mclks_pkg::lfsr_step(lfsr_one,   mclks_pkg::MASK_ONE,   maj);
    step_two   = mclks_pkg::lfsr_step(lfsr_two,   mclks_pkg::MASK_TWO,   maj);
    step_three = mclks_pkg::lfsr_step(lfsr_three, mclks_pkg::MASK_THREE, maj);
    stream_bit = step_one[63] ^ step_two[63] ^ step_three[63];
    acc_shift  = {acc[62:0], stream_bit};
    last_bit   = (count == mclks_pkg::CNT_W'(mclks_pkg::TOTAL_BITS - 1));
    word_end   = (count[5:0] == 6'h3F) || last_bit;
    stall      = word_end && out_valid && !word.ready;
  end

  // sequencer: load, frame mixing, silent run, keystream output
  always_comb begin
    state_next      = state;
    count_next      = count;
    lfsr_one_next   = lfsr_one;
    lfsr_two_next   = lfsr_two;
    lfsr_three_next = lfsr_three;
    frame_next      = frame;
    acc_next        = acc;
    item_pop        = 1'b0;
    emit            = 1'b0;
    unique case (state)
      mclks_pkg::ST_IDLE: begin
        item_pop = 1'b1;
        if (item_valid) begin
          lfsr_one_next   = item.key_word_one;
          lfsr_two_next   = item.key_word_two;
          lfsr_three_next = item.key_word_three;
          frame_next      = item.frame_value;
          count_next      = '0;
          state_next      = mclks_pkg::ST_FRAME;
        end
      end
      mclks_pkg::ST_FRAME: begin
        lfsr_one_next   = step_one   ^ {63'd0, frame[0]};
        lfsr_two_next   = step_two   ^ {63'd0, frame[0]};
        lfsr_three_next = step_three ^ {63'd0, frame[0]};
        frame_next      = {1'b0, frame[63:1]};
        count_next      = count + 1'b1;
        if (count == mclks_pkg::CNT_W'(mclks_pkg::FRAME_CLOCKS - 1)) begin
          count_next = '0;
          state_next = mclks_pkg::ST_SILENT;
        end
      end
      mclks_pkg::ST_SILENT: begin
        lfsr_one_next   = step_one;
        lfsr_two_next   = step_two;
        lfsr_three_next = step_three;
        count_next      = count + 1'b1;
        if (count == mclks_pkg::CNT_W'(mclks_pkg::SILENT_CLOCKS - 1)) begin
          count_next = '0;
          state_next = mclks_pkg::ST_STREAM;
        end
      end
      mclks_pkg::ST_STREAM: begin
        if (!stall) begin
          lfsr_one_next   = step_one;
          lfsr_two_next   = step_two;
          lfsr_three_next = step_three;
          acc_next        = acc_shift;
          count_next      = count + 1'b1;
          emit            = word_end;
          if (last_bit) begin
            count_next = '0;
            state_next = mclks_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = mclks_pkg::ST_IDLE;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (word.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mclks_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lfsr_one   <= lfsr_one_next;
    lfsr_two   <= lfsr_two_next;
    lfsr_three <= lfsr_three_next;
    frame      <= frame_next;
    acc        <= acc_next;
  end

  // output word, left-aligned when it is the short final word
  always_ff @(posedge clk) begin
    if (emit) begin
      out_last <= last_bit;
      if (last_bit) begin
        out_word  <= acc_shift << mclks_pkg::LAST_SHIFT;
        out_bytes <= 4'(mclks_pkg::LAST_BYTES);
      end else begin
        out_word  <= acc_shift;
        out_bytes <= 4'(mclks_pkg::BYTES_PER_WORD);
      end
    end
  end

  assign word.valid       = out_valid;
  assign word.stream_word = out_word;
  assign word.valid_bytes = out_bytes;
  assign word.last_word   = out_last;

endmodule

// ===== hdl/majority_clocked_lfsr_keystream_core.sv =====
// channel   dir  payload                                             role
// req       in   key_word_one, key_word_two, key_word_three,         one request per keystream
//                frame_value
// word      out  stream_word, valid_bytes, last_word                 16 words per request
//
// a request passes the front stage and queue; the sequencer loads it, mixes in the 64-bit
// frame value, runs silent and outputs 126 keystream bytes, stepping registers by majority
// the register sequencer runs once per cycle unless stalled on output and sets the rate
// a word not taken stalls the sequencer at the next word boundary only
// the front stage and two-entry queue keep taking requests while the sequencer runs
// synchronous active-high reset clears all handshake and sequencer state
module majority_clocked_lfsr_keystream_core (
  input  logic         clk,
  input  logic         rst,
  mclks_req_if.sink    req,
  mclks_word_if.source word
);

  logic            push;
  mclks_pkg::req_t push_item;
  logic            queue_full;
  logic            pop_valid;
  mclks_pkg::req_t pop_item;
  logic            pop;

  // request intake
  mclks_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // pending requests
  mclks_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop)
  );

  // keystream sequencer
  mclks_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item       (pop_item),
    .item_pop   (pop),
    .word       (word)
  );

endmodule

// ===== hdl/mclks_checker.sv =====
`include "majority_clocked_lfsr_keystream_core_macros.svh"

module mclks_checker (
  input logic        clk,
  input logic        rst,
  input logic        word_valid,
  input logic        word_ready,
  input logic [63:0] stream_word,
  input logic [3:0]  valid_bytes,
  input logic        last_word
);

  // only the final word may be short, and never empty
  `MCLKS_ASSERT_IMPL(a_full_words, word_valid && !last_word, valid_bytes == 4'd8)
  `MCLKS_ASSERT_IMPL(a_bytes_range, word_valid, valid_bytes != 4'd0 && valid_bytes <= 4'd8)
  // a stalled word holds its data word and last flag
  `MCLKS_ASSERT_NEXT(a_hold, word_valid && !word_ready,
                     word_valid && $stable(stream_word) && $stable(last_word))
  // the next request needs a full run of the sequencer
  `MCLKS_ASSERT_NEXT(a_gap_after_last, word_valid && word_ready && last_word, !word_valid)
  // nothing leaves right after reset
  `MCLKS_ASSERT_NEXT_ALWAYS(a_reset_quiet, rst, !word_valid)

endmodule

bind majority_clocked_lfsr_keystream_core mclks_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .word_valid  (word.valid),
  .word_ready  (word.ready),
  .stream_word (word.stream_word),
  .valid_bytes (word.valid_bytes),
  .last_word   (word.last_word)
);
